// File: rtl/ppf_pkg.sv
// Shared types and constants for the prebuffered playout FIFO.
package ppf_pkg;

   localparam int FIFO_DEPTH_DEF = 4096;
   localparam int THR_W          = 13;
   localparam int TMO_W          = 16;
   localparam int FILL_W         = 13;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic [THR_W-1:0] THR_RESET = '0;
   localparam logic [TMO_W-1:0] TMO_RESET = TMO_W'(1000);

   // Register select, taken from the word address bit.
   localparam logic REG_THRESHOLD = 1'b0;
   localparam logic REG_TIMEOUT   = 1'b1;

   // Command codes.
   localparam logic [2:0] MODE_WRITE = 3'd0;
   localparam logic [2:0] MODE_READ  = 3'd1;
   localparam logic [2:0] MODE_EOS   = 3'd2;
   localparam logic [2:0] MODE_TICK  = 3'd3;
   localparam logic [2:0] MODE_START = 3'd4;
   localparam logic [2:0] MODE_STOP  = 3'd5;

   // Result status codes.
   localparam logic [2:0] ST_DELIVERED = 3'd0;
   localparam logic [2:0] ST_NO_DATA   = 3'd1;
   localparam logic [2:0] ST_END       = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_DONE      = 3'd4;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] in_byte;
   } ppf_req_type;

   typedef struct packed {
      logic [7:0]        out_byte;
      logic [2:0]        status;
      logic [FILL_W-1:0] fill_level;
      logic              is_buffering;
   } ppf_rsp_type;

endpackage

// File: rtl/ppf_ram.sv
// Byte store: one write port, one registered read port.
module ppf_ram
   import ppf_pkg::*;
#(
   parameter int DEPTH  = FIFO_DEPTH_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/prebuffered_playout_fifo.sv
// Top level of the prebuffered playout FIFO: command decode, gate and pointers.
//
// Byte FIFO for audio playout with a prebuffer gate in front of the reader.
// Commands arrive on req_data (mode, in_byte) and are taken on any clock where
// start is high; busy is always low, so one command can be issued every cycle.
// Every command yields exactly one result beat: rsp_valid pulses for one cycle
// with rsp_data (out_byte, status, fill_level, is_buffering).
// The result strobes once the command has passed the input register and then
// the state update and the registered byte store read.
// Throughput: one command per cycle, set by the single-port-write byte store
// that is written and read once per cycle.
// The receiver cannot stall; the result is present for its one cycle only.
// Reset (synchronous) empties the FIFO, clears the end mark, arms the gate,
// zeroes the tick counter and loads the registers with their defaults
// (threshold 0, timeout 1000 ticks). No clearing pass is needed: the store
// contents are never read before being written.
// Registers on the APB port: threshold at byte address 0, timeout at 4.
module prebuffered_playout_fifo
   import ppf_pkg::*;
#(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // command channel
   input  logic                  start,
   output logic                  busy,
   input  ppf_req_type           req_data,
   // result channel
   output logic                  rsp_valid,
   output ppf_rsp_type           rsp_data,
   // configuration
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

   // ---------------- configuration registers ----------------
   logic [THR_W-1:0] thr_ff;
   logic [TMO_W-1:0] tmo_ff;
   logic             csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
         tmo_ff <= TMO_RESET;
      end else if (csr_wr) begin
         if (paddr[2] == REG_THRESHOLD) begin
            thr_ff <= pwdata[THR_W-1:0];
         end else begin
            tmo_ff <= pwdata[TMO_W-1:0];
         end
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_TIMEOUT) begin
         prdata[TMO_W-1:0] = tmo_ff;
      end else begin
         prdata[THR_W-1:0] = thr_ff;
      end
   end

   // ---------------- input register ----------------
   logic        req_vld_ff;
   ppf_req_type req_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
   end

   // ---------------- FIFO and gate state ----------------
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             end_ff, end_in;
   logic             buf_ff, buf_in;
   logic [TMO_W-1:0] wait_ff, wait_in;

   logic             gate_on;
   logic             release_gate;
   logic             full;
   logic             mem_wr;
   logic             deliver;
   logic [2:0]       status_in;

   assign full    = (count_ff == CNT_FULL);
   assign gate_on = buf_ff && (thr_ff != '0);
   assign release_gate = end_ff
                      || (CMP_W'(count_ff) >= CMP_W'(thr_ff))
                      || (wait_ff >= tmo_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      end_in    = end_ff;
      buf_in    = buf_ff;
      wait_in   = wait_ff;
      mem_wr    = 1'b0;
      deliver   = 1'b0;
      status_in = ST_DONE;
      case (req_ff.mode)
         MODE_WRITE: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               mem_wr    = 1'b1;
               wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
               count_in  = count_ff + CNT_W'(1);
            end
         end
         MODE_READ: begin
            if (gate_on && !release_gate) begin
               status_in = ST_NO_DATA;         // gate still closed
            end else begin
               if (gate_on) begin
                  buf_in = 1'b0;
               end
               if (count_ff != '0) begin
                  deliver   = 1'b1;
                  status_in = ST_DELIVERED;
                  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
                  count_in  = count_ff - CNT_W'(1);
               end else if (!end_ff) begin
                  // underrun before end of stream: rearm the gate
                  buf_in    = 1'b1;
                  wait_in   = '0;
                  status_in = ST_NO_DATA;
               end else begin
                  status_in = ST_END;
               end
            end
         end
         MODE_EOS: begin
            end_in = 1'b1;
         end
         MODE_TICK: begin
            if (buf_ff && (wait_ff != '1)) begin
               wait_in = wait_ff + TMO_W'(1);
            end
         end
         MODE_START: begin
            wr_ptr_in = '0;
            rd_ptr_in = '0;
            count_in  = '0;
            end_in    = 1'b0;
            buf_in    = 1'b1;
            wait_in   = '0;
         end
         MODE_STOP: begin
            wr_ptr_in = '0;
            rd_ptr_in = '0;
            count_in  = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         end_ff    <= 1'b0;
         buf_ff    <= 1'b1;
         wait_ff   <= '0;
      end else if (req_vld_ff) begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         end_ff    <= end_in;
         buf_ff    <= buf_in;
         wait_ff   <= wait_in;
      end
   end

   // ---------------- byte store ----------------
   logic [7:0] rd_byte;

   ppf_ram #(
      .DEPTH  (FIFO_DEPTH),
      .ADDR_W (PTR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (req_vld_ff && mem_wr),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_ff.in_byte),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_byte)
   );

   // ---------------- result register ----------------
   // Fill level comes straight from count_ff, which holds the post-item value
   // during the strobe cycle.
   logic       rsp_vld_ff;
   logic       deliver_ff;
   logic [2:0] status_ff;
   logic       isbuf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= req_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_vld_ff) begin
         deliver_ff <= deliver;
         status_ff  <= status_in;
         isbuf_ff   <= buf_in && (thr_ff != '0);
      end
   end

   assign rsp_valid              = rsp_vld_ff;
   assign rsp_data.out_byte      = deliver_ff ? rd_byte : 8'd0;
   assign rsp_data.status        = status_ff;
   assign rsp_data.fill_level    = FILL_W'(count_ff);
   assign rsp_data.is_buffering  = isbuf_ff;

   // ---------------- assertions ----------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("fifo count above depth");

   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##2 rsp_valid)
      else $error("result beat missing two cycles after command");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_DELIVERED) |-> rsp_data.out_byte == 8'd0)
      else $error("byte driven on a non-delivery result");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      req_vld_ff && (req_ff.mode == MODE_START) |=> (count_ff == '0) && !end_ff && buf_ff)
      else $error("start did not clear the fifo");

endmodule

// File: test/testbench.sv
// Self-checking testbench for the prebuffered playout FIFO: shadow model, command and CSR drivers.
module testbench;
   import ppf_pkg::*;

   localparam int CLK_PERIOD = 20;
   localparam int DEPTH      = FIFO_DEPTH_DEF;
   // Modes six and seven decode to nothing; named here since the package stops at stop.
   localparam logic [2:0] MODE_SPARE6 = 3'd6;
   localparam logic [2:0] MODE_SPARE7 = 3'd7;
   // Result beat trails the accepting edge through the input and result registers; the tail adds slack.
   localparam int TAIL_CYCLES = 6;

   // Shadow of the playout FIFO. note_command advances it by one accepted beat and
   // queues the result beat it predicts; check_result pops and compares.
   class playout_scoreboard;
      logic [7:0]  shadow_bytes [DEPTH];
      int unsigned wr_idx, rd_idx, held_count, waited;
      bit          end_mark, gating;
      logic [12:0] threshold;
      logic [15:0] timeout;
      ppf_rsp_type awaited_beats [$];
      int          mismatches, beats_checked;

      function new();
         wr_idx = 0; rd_idx = 0; held_count = 0; waited = 0;
         end_mark = 1'b0; gating = 1'b1;
         threshold = THR_RESET; timeout = TMO_RESET;
         mismatches = 0; beats_checked = 0;
      endfunction

      function bit gate_on();
         return gating && threshold != '0;
      endfunction

      function void drop_contents();
         wr_idx = 0; rd_idx = 0; held_count = 0;
      endfunction

      function void note_command(ppf_req_type cmd);
         ppf_rsp_type beat;
         bit          hold;
         beat = '0;
         beat.status = ST_DONE;
         hold = 1'b0;
         case (cmd.mode)
            MODE_WRITE: begin
               if (held_count >= DEPTH) begin
                  beat.status = ST_FULL;
               end else begin
                  shadow_bytes[wr_idx] = cmd.in_byte;
                  wr_idx = (wr_idx + 1) % DEPTH;
                  held_count++;
               end
            end
            MODE_READ: begin
               if (gate_on()) begin
                  if (end_mark || held_count >= threshold || waited >= timeout)
                     gating = 1'b0;
                  else
                     hold = 1'b1;
               end
               if (hold) begin
                  beat.status = ST_NO_DATA;
               end else if (held_count > 0) begin
                  beat.out_byte = shadow_bytes[rd_idx];
                  rd_idx = (rd_idx + 1) % DEPTH;
                  held_count--;
                  beat.status = ST_DELIVERED;
               end else if (!end_mark) begin
                  gating = 1'b1;
                  waited = 0;
                  beat.status = ST_NO_DATA;
               end else begin
                  beat.status = ST_END;
               end
            end
            MODE_EOS: end_mark = 1'b1;
            MODE_TICK: begin
               if (gating && waited < 16'hFFFF) waited++;
            end
            MODE_START: begin
               drop_contents();
               end_mark = 1'b0;
               gating = 1'b1;
               waited = 0;
            end
            MODE_STOP: drop_contents();
            default: ;
         endcase
         beat.fill_level = held_count[FILL_W-1:0];
         beat.is_buffering = gate_on();
         awaited_beats.push_back(beat);
      endfunction

      task report(string field, int got, int want);
         $display("%0t: mismatch on %s: got %0d, want %0d", $time, field, got, want);
         mismatches++;
      endtask

      task check_result(ppf_rsp_type got);
         ppf_rsp_type want;
         if (awaited_beats.size() == 0) begin
            report("unexpected beat, status", got.status, -1);
         end else begin
            want = awaited_beats.pop_front();
            beats_checked++;
            if (got.out_byte !== want.out_byte)
               report("out_byte", got.out_byte, want.out_byte);
            if (got.status !== want.status)
               report("status", got.status, want.status);
            if (got.fill_level !== want.fill_level)
               report("fill_level", got.fill_level, want.fill_level);
            if (got.is_buffering !== want.is_buffering)
               report("is_buffering", got.is_buffering, want.is_buffering);
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset   = 1'b1;
   logic                  start   = 1'b0;
   logic                  busy;
   ppf_req_type           req_data = '0;
   logic                  rsp_valid;
   ppf_rsp_type           rsp_data;
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   playout_scoreboard board;
   int sender_idle_pct = 0;   // chance, per cycle, that the sender holds start low
   int cmds_sent       = 0;
   int csr_writes      = 0;

   prebuffered_playout_fifo dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Monitor: sample on the edge, where inputs and outputs still hold their
   // pre-edge values. Note first so a short-latency beat would find its entry.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.note_command(req_data);
         if (rsp_valid) board.check_result(rsp_data);
      end
   end

   // One command beat. Idle gaps are drawn per cycle; start is only lowered
   // in a gap, so it never drops and rises within one step.
   task automatic send_cmd(input logic [2:0] mode, input logic [7:0] data);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= '{mode: mode, in_byte: data};
      @(posedge clock);
      while (busy) @(posedge clock);
      cmds_sent++;
   endtask

   // Hold off until every predicted beat has come back.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.awaited_beats.size() != 0) @(posedge clock);
   endtask

   // APB write: setup cycle, then access until pready. Upper data bits get junk.
   task automatic csr_write(input logic sel, input int unsigned value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= CSR_ADDR_W'({sel, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      csr_writes++;
   endtask

   // Registers change only with the block idle.
   task automatic set_config(input logic [12:0] thr, input logic [15:0] tmo);
      int unsigned junk;
      drain();
      junk = $urandom;
      csr_write(REG_THRESHOLD, {junk[31:13], thr});
      board.threshold = thr;
      junk = $urandom;
      csr_write(REG_TIMEOUT, {junk[31:16], tmo});
      board.timeout = tmo;
   endtask

   // Well-formed playout session: start, a burst of writes, then reads past
   // empty, with ticks sprinkled in and sometimes an end mark or an early stop.
   task automatic run_session();
      int n_wr, n_rd, eos_at;
      n_wr   = $urandom_range(0, 24);
      n_rd   = n_wr + $urandom_range(1, 4);
      eos_at = ($urandom_range(99) < 30) ? $urandom_range(0, n_rd - 1) : -1;
      send_cmd(MODE_START, 8'($urandom));
      for (int i = 0; i < n_wr; i++) begin
         send_cmd(MODE_WRITE, 8'($urandom));
         if ($urandom_range(99) < 25) send_cmd(MODE_TICK, 8'($urandom));
      end
      for (int j = 0; j < n_rd; j++) begin
         if (j == eos_at) send_cmd(MODE_EOS, 8'($urandom));
         if ($urandom_range(99) < 15) send_cmd(MODE_TICK, 8'($urandom));
         if ($urandom_range(99) < 3) send_cmd(MODE_STOP, 8'($urandom));
         send_cmd(MODE_READ, 8'($urandom));
      end
   endtask

   initial begin
      logic [12:0] thr;
      logic [15:0] tmo;
      int          chunk_base;
      int          idle_plan [3];

      board = new();
      idle_plan = '{8, 70, 0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: gate off at reset (threshold 0).
      send_cmd(MODE_READ, 8'h00);      // empty, no end mark: no data, rearm
      send_cmd(MODE_WRITE, 8'h00);
      send_cmd(MODE_WRITE, 8'hFF);
      send_cmd(MODE_READ, 8'hFF);
      send_cmd(MODE_READ, 8'h00);
      send_cmd(MODE_EOS, 8'h00);
      send_cmd(MODE_READ, 8'h00);      // empty with end mark
      send_cmd(MODE_TICK, 8'h00);
      send_cmd(MODE_SPARE6, 8'hFF);
      send_cmd(MODE_SPARE7, 8'hFF);
      send_cmd(MODE_STOP, 8'h00);
      send_cmd(MODE_START, 8'h00);

      // Gate on, short timeout: held read, release by timeout, rearm on empty.
      set_config(13'd3, 16'd2);
      send_cmd(MODE_WRITE, 8'hA5);
      send_cmd(MODE_READ, 8'h00);
      send_cmd(MODE_TICK, 8'h00);
      send_cmd(MODE_TICK, 8'h00);
      send_cmd(MODE_READ, 8'h00);
      send_cmd(MODE_READ, 8'h00);
      // Release by end mark.
      send_cmd(MODE_WRITE, 8'h5A);
      send_cmd(MODE_READ, 8'h00);
      send_cmd(MODE_EOS, 8'h00);
      send_cmd(MODE_READ, 8'h00);

      // Threshold beyond depth, zero timeout: first read opens at once.
      set_config(13'h1FFF, 16'd0);
      send_cmd(MODE_START, 8'h00);
      send_cmd(MODE_READ, 8'h00);
      send_cmd(MODE_WRITE, 8'h3C);

      // Offset the pointers, then release by fill at exactly the threshold
      // and drain past empty so the gate rearms.
      set_config(13'd0, 16'd1000);
      repeat (10) send_cmd(MODE_WRITE, 8'($urandom));
      repeat (11) send_cmd(MODE_READ, 8'($urandom));
      set_config(13'd5, 16'hFFFF);
      repeat (4) send_cmd(MODE_WRITE, 8'($urandom));
      send_cmd(MODE_TICK, 8'h00);
      send_cmd(MODE_READ, 8'h00);      // one byte short: still held
      send_cmd(MODE_WRITE, 8'($urandom));
      repeat (6) send_cmd(MODE_READ, 8'h00);

      // Random part: three idle regimes, four register settings each.
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = idle_plan[phase];
         for (int chunk = 0; chunk < 4; chunk++) begin
            case ($urandom_range(0, 5))
               0:       thr = 13'd0;
               1:       thr = 13'd1;
               2, 3:    thr = 13'($urandom_range(2, 24));
               4:       thr = ($urandom_range(1)) ? 13'h1FFF : 13'(DEPTH);
               default: thr = 13'($urandom);
            endcase
            case ($urandom_range(0, 3))
               0:       tmo = 16'd0;
               1:       tmo = 16'($urandom_range(1, 8));
               2:       tmo = 16'hFFFF;
               default: tmo = 16'($urandom);
            endcase
            set_config(thr, tmo);
            chunk_base = cmds_sent;
            while (cmds_sent - chunk_base < 75) begin
               if ($urandom_range(99) < 80) begin
                  run_session();
               end else begin
                  repeat ($urandom_range(1, 10))
                     send_cmd(3'($urandom_range(0, 7)), 8'($urandom));
               end
               if ($urandom_range(99) < 5) drain();
            end
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d command beats (%0d results checked) over %0d register writes,",
               cmds_sent, board.beats_checked, csr_writes);
      $display("incl. gate release by fill, timeout and end mark, underrun rearm, spare modes.");
      if (board.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #(CLK_PERIOD * 3000000);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: prebuffered_playout_fifo.f
rtl/ppf_pkg.sv
rtl/ppf_ram.sv
rtl/prebuffered_playout_fifo.sv
test/testbench.sv
